/* sv/hgts_pkg.sv */
// Shared types and constants for the height grid triangle sampler.
`timescale 1ns / 1ps
package hgts_pkg;

    localparam int HEIGHT_W = 16;
    localparam int COORD_W  = 16;
    localparam int ROWCOL_W = 6;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                       opcode;
        logic [ROWCOL_W-1:0]        write_row;
        logic [ROWCOL_W-1:0]        write_col;
        logic signed [HEIGHT_W-1:0] write_height;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_z;
    } cmd_item_t;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       in_range;
    } res_item_t;

    typedef struct packed {
        logic start;    // load accumulator with this product
        logic en;       // take this product
    } mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_MAC_C,
        ST_FINISH
    } seq_state_t;

endpackage

/* sv/height_grid_triangle_sample.sv */
// Height grid triangle sampler: sequencer, grid memory and blend datapath.
// A write item is taken in the idle state and gives no result. A query inside
// the grid steps through ST_RD_A, ST_RD_B, ST_RD_C, ST_MAC_C and ST_FINISH
// before the next item is taken: the three corner heights come one per cycle
// from the single-port grid memory (registered read) and each is weighted by
// one multiply-accumulate, then the sum is floored into the result register.
// A query outside the grid goes straight to ST_FINISH; the result register
// lets the next item be taken while a result is still held, and a query waits
// in its last step only while that register is full and stalled. The grid has
// no reset and no clearing pass: an unwritten cell reads an unspecified height.
`timescale 1ns / 1ps
module height_grid_triangle_sample
    import hgts_pkg::*;
#(
    parameter int GRID_SIZE = 64,
    parameter int FRAC_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    localparam int IDX_W  = $clog2(GRID_SIZE);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int CI_W   = COORD_W - FRAC_BITS;
    localparam int W_W    = FRAC_BITS + 1;
    localparam int ACC_W  = HEIGHT_W + FRAC_BITS + 3;
    localparam logic [W_W-1:0] ONE_W = W_W'(1 << FRAC_BITS);
    localparam logic signed [HEIGHT_W-1:0] NEG_ONE = HEIGHT_W'(-(1 << FRAC_BITS));

    seq_state_t state_reg, state_next;

    // query decode
    logic [CI_W-1:0]        ci, cj;
    logic [IDX_W+CI_W-1:0]  ci_wide, cj_wide;
    logic [FRAC_BITS-1:0]   s, t;
    logic                   upper;
    logic                   q_ok;
    logic [W_W-1:0]         wa, wb, wc;

    logic [IDX_W-1:0] i_reg, j_reg;
    logic [IDX_W-1:0] i_inc, j_inc;
    logic [W_W-1:0]   wa_reg, wb_reg, wc_reg;
    logic             upper_reg;
    logic             ok_reg;

    // write decode
    logic [IDX_W+ROWCOL_W-1:0] row_wide, col_wide;
    logic                      wr_ok;

    logic                       cmd_take;
    logic                       res_free;
    logic                       res_load;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_addr;
    logic signed [HEIGHT_W-1:0] mem_rdata;
    mac_ctl_t                   mac_ctl;
    logic [W_W-1:0]             mac_weight;
    logic signed [ACC_W-1:0]    acc;

    logic                       res_valid_reg, res_valid_next;
    res_item_t                  res_reg;

    assign cmd_take = cmd_valid && !cmd_stall;
    assign res_free = !res_valid_reg || !res_stall;

    assign ci      = cmd.pos_x[COORD_W-1:FRAC_BITS];
    assign cj      = cmd.pos_z[COORD_W-1:FRAC_BITS];
    assign ci_wide = {{IDX_W{1'b0}}, ci};
    assign cj_wide = {{IDX_W{1'b0}}, cj};
    assign s       = cmd.pos_x[FRAC_BITS-1:0];
    assign t       = cmd.pos_z[FRAC_BITS-1:0];
    assign upper   = (s >= t);
    // negative coordinates and cells past the last full cell are out of range
    assign q_ok    = !cmd.pos_x[COORD_W-1] && !cmd.pos_z[COORD_W-1]
                     && (int'(ci) <= GRID_SIZE - 2) && (int'(cj) <= GRID_SIZE - 2);

    always_comb
    begin
        if (upper)
        begin
            wa = ONE_W - {1'b0, s};
            wb = {1'b0, s} - {1'b0, t};
            wc = {1'b0, t};
        end
        else
        begin
            wa = ONE_W - {1'b0, t};
            wb = {1'b0, t} - {1'b0, s};
            wc = {1'b0, s};
        end
    end

    assign row_wide = {{IDX_W{1'b0}}, cmd.write_row};
    assign col_wide = {{IDX_W{1'b0}}, cmd.write_col};
    assign wr_ok    = (int'(cmd.write_row) < GRID_SIZE) && (int'(cmd.write_col) < GRID_SIZE);

    assign i_inc = i_reg + IDX_W'(1);
    assign j_inc = j_reg + IDX_W'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && cmd.opcode == OP_QUERY)
                begin
                    state_next = q_ok ? ST_RD_A : ST_FINISH;
                end
            end
            ST_RD_A:  state_next = ST_RD_B;
            ST_RD_B:  state_next = ST_RD_C;
            ST_RD_C:  state_next = ST_MAC_C;
            ST_MAC_C: state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        cmd_stall  = 1'b1;
        mem_we     = 1'b0;
        mem_addr   = {i_reg, j_reg};
        mac_ctl    = '0;
        mac_weight = wa_reg;
        res_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_stall = 1'b0;
                mem_we    = cmd_valid && (cmd.opcode == OP_WRITE) && wr_ok;
                mem_addr  = {row_wide[IDX_W-1:0], col_wide[IDX_W-1:0]};
            end
            ST_RD_A:
            begin
                mem_addr = {i_reg, j_reg};
            end
            ST_RD_B:
            begin
                mem_addr   = upper_reg ? {i_reg, j_inc} : {i_inc, j_reg};
                mac_ctl    = '{start: 1'b1, en: 1'b1};
                mac_weight = wa_reg;
            end
            ST_RD_C:
            begin
                mem_addr   = {i_inc, j_inc};
                mac_ctl    = '{start: 1'b0, en: 1'b1};
                mac_weight = wb_reg;
            end
            ST_MAC_C:
            begin
                mac_ctl    = '{start: 1'b0, en: 1'b1};
                mac_weight = wc_reg;
            end
            ST_FINISH:
            begin
                res_load = res_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd.opcode == OP_QUERY)
        begin
            i_reg     <= ci_wide[IDX_W-1:0];
            j_reg     <= cj_wide[IDX_W-1:0];
            wa_reg    <= wa;
            wb_reg    <= wb;
            wc_reg    <= wc;
            upper_reg <= upper;
            ok_reg    <= q_ok;
        end
    end

    hgts_grid_mem #(
        .ADDR_W (ADDR_W)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (cmd.write_height),
        .rdata (mem_rdata)
    );

    hgts_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .clk    (clk),
        .ctl    (mac_ctl),
        .height (mem_rdata),
        .weight (mac_weight),
        .acc    (acc)
    );

    // result register
    assign res_valid_next = res_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            // arithmetic shift floors toward minus infinity
            res_reg.height_out <= ok_reg ? acc[FRAC_BITS+HEIGHT_W-1:FRAC_BITS] : NEG_ONE;
            res_reg.in_range   <= ok_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* sv/hgts_grid_mem.sv */
// Single-port height grid memory with registered read data.
`timescale 1ns / 1ps
module hgts_grid_mem
    import hgts_pkg::*;
#(
    parameter int ADDR_W = 12
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          addr,
    input  logic signed [HEIGHT_W-1:0] wdata,
    output logic signed [HEIGHT_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic signed [HEIGHT_W-1:0] mem [DEPTH];
    logic signed [HEIGHT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/hgts_mac.sv */
// Multiply-accumulate of corner heights by barycentric weights.
`timescale 1ns / 1ps
module hgts_mac
    import hgts_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                                  clk,
    input  mac_ctl_t                              ctl,
    input  logic signed [HEIGHT_W-1:0]            height,
    input  logic [FRAC_BITS:0]                    weight,
    output logic signed [HEIGHT_W+FRAC_BITS+2:0]  acc
);

    localparam int PROD_W = HEIGHT_W + FRAC_BITS + 2;
    localparam int ACC_W  = HEIGHT_W + FRAC_BITS + 3;

    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    assign prod     = height * $signed({1'b0, weight});
    assign prod_ext = {prod[PROD_W-1], prod};

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.en)
        begin
            acc_next = ctl.start ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* tb/tb_height_grid_triangle_sample.sv */
// Self-checking testbench for the height grid triangle sampler.
`timescale 1ns / 1ps
module tb_height_grid_triangle_sample;
    import hgts_pkg::*;

    localparam int GRID_N      = 64;
    localparam int FRAC_N      = 8;
    localparam int LAST_CELL   = GRID_N - 2;
    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 16;
    localparam logic signed [HEIGHT_W-1:0] OFF_GRID_H = -(16'sd1 <<< FRAC_N);

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_stall;
    cmd_item_t cmd = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    // predictor state: heights plus a written mark per grid entry
    logic signed [HEIGHT_W-1:0] grid_h  [GRID_N*GRID_N];
    bit                         grid_wr [GRID_N*GRID_N];
    res_item_t                  expected_samples [$];

    int        tx_idle_pct = 29;
    int        rx_idle_pct = 29;
    int        holdoff_left = 0;
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        stuck_cycles = 0;
    res_item_t want;

    height_grid_triangle_sample dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int cell_idx(int r, int c);
        return r * GRID_N + c;
    endfunction

    // Blend of the cell triangle, floored; returns 1 when the item gives a result.
    function automatic bit sample_model(input cmd_item_t it, output res_item_t r);
        int     i, j, s, t;
        longint a, b, c, d, sum;
        longint one_fx;
        one_fx = longint'(1) << FRAC_N;
        r = '0;
        if (it.opcode == OP_WRITE)
        begin
            grid_h[cell_idx(int'(it.write_row), int'(it.write_col))]  = it.write_height;
            grid_wr[cell_idx(int'(it.write_row), int'(it.write_col))] = 1'b1;
            return 1'b0;
        end
        r.height_out = OFF_GRID_H;
        r.in_range   = 1'b0;
        if (it.pos_x[COORD_W-1] || it.pos_z[COORD_W-1])
            return 1'b1;
        i = int'(it.pos_x[COORD_W-2:FRAC_N]);
        j = int'(it.pos_z[COORD_W-2:FRAC_N]);
        s = int'(it.pos_x[FRAC_N-1:0]);
        t = int'(it.pos_z[FRAC_N-1:0]);
        if (i > LAST_CELL || j > LAST_CELL)
            return 1'b1;
        a = longint'(grid_h[cell_idx(i, j)]);
        c = longint'(grid_h[cell_idx(i + 1, j + 1)]);
        if (s >= t)
        begin
            b = longint'(grid_h[cell_idx(i, j + 1)]);
            sum = a * (one_fx - s) + b * (s - t) + c * t;
        end
        else
        begin
            d = longint'(grid_h[cell_idx(i + 1, j)]);
            sum = a * (one_fx - t) + d * (t - s) + c * s;
        end
        r.height_out = 16'(sum >>> FRAC_N);
        r.in_range   = 1'b1;
        return 1'b1;
    endfunction

    // Offer one item, with random idle cycles first; returns at the accepting edge.
    task automatic send_item(cmd_item_t it);
        res_item_t r;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= it;
        do
            @(posedge clk);
        while (cmd_stall);
        items_sent++;
        if (sample_model(it, r))
            expected_samples = {expected_samples, r};
    endtask

    function automatic cmd_item_t random_item(logic op);
        cmd_item_t x;
        x.opcode       = op;
        x.write_row    = ROWCOL_W'($urandom);
        x.write_col    = ROWCOL_W'($urandom);
        x.write_height = HEIGHT_W'($urandom);
        x.pos_x        = COORD_W'($urandom);
        x.pos_z        = COORD_W'($urandom);
        return x;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] random_height();
        case ($urandom_range(7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return HEIGHT_W'($urandom);
        endcase
    endfunction

    task automatic write_cell(int r, int c, logic signed [HEIGHT_W-1:0] h);
        cmd_item_t it;
        it = random_item(OP_WRITE);
        it.write_row    = ROWCOL_W'(r);
        it.write_col    = ROWCOL_W'(c);
        it.write_height = h;
        send_item(it);
    endtask

    task automatic ensure_written(int r, int c);
        if (!grid_wr[cell_idx(r, c)])
            write_cell(r, c, random_height());
    endtask

    task automatic send_query(logic [COORD_W-1:0] px, logic [COORD_W-1:0] pz);
        cmd_item_t it;
        it = random_item(OP_QUERY);
        it.pos_x = px;
        it.pos_z = pz;
        send_item(it);
    endtask

    // Corners of the chosen triangle are written first so no unwritten entry is read.
    task automatic query_cell(int i, int j, int s, int t);
        ensure_written(i, j);
        ensure_written(i + 1, j + 1);
        if (s >= t)
            ensure_written(i, j + 1);
        else
            ensure_written(i + 1, j);
        send_query({1'b0, 7'(i), 8'(s)}, {1'b0, 7'(j), 8'(t)});
    endtask

    function automatic int random_frac();
        case ($urandom_range(9))
            0:       return 0;
            1:       return (1 << FRAC_N) - 1;
            default: return $urandom_range((1 << FRAC_N) - 1);
        endcase
    endfunction

    function automatic int random_cell_index();
        case ($urandom_range(5))
            0:       return LAST_CELL;
            1, 2:    return $urandom_range(5);
            default: return $urandom_range(LAST_CELL);
        endcase
    endfunction

    task automatic random_query_in_grid();
        int i, j, s, t;
        i = random_cell_index();
        j = random_cell_index();
        s = random_frac();
        t = ($urandom_range(5) == 0) ? s : random_frac();
        query_cell(i, j, s, t);
    endtask

    task automatic random_noise_query();
        cmd_item_t it;
        it = random_item(OP_QUERY);
        if ($urandom_range(3) == 0)
            it.pos_x[COORD_W-2:FRAC_N] = 7'(LAST_CELL + 1);
        if (!it.pos_x[COORD_W-1] && !it.pos_z[COORD_W-1]
            && it.pos_x[COORD_W-2:FRAC_N] <= LAST_CELL && it.pos_z[COORD_W-2:FRAC_N] <= LAST_CELL)
            query_cell(int'(it.pos_x[COORD_W-2:FRAC_N]), int'(it.pos_z[COORD_W-2:FRAC_N]),
                       int'(it.pos_x[FRAC_N-1:0]), int'(it.pos_z[FRAC_N-1:0]));
        else
            send_item(it);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corner_extremes();
        write_cell(0, 0, 16'sh7FFF);
        write_cell(0, 1, 16'sh8000);
        write_cell(1, 1, 16'sh7FFF);
        write_cell(1, 0, 16'sh8000);
        query_cell(0, 0, 0, 0);
        query_cell(0, 0, 255, 0);
        query_cell(0, 0, 0, 255);
        query_cell(0, 0, 128, 128);
        query_cell(0, 0, 255, 255);
        query_cell(0, 0, 37, 200);
    endtask

    task automatic test_edge_cells();
        write_cell(LAST_CELL, LAST_CELL, 16'sh0000);
        write_cell(LAST_CELL, LAST_CELL + 1, -16'sd1);
        write_cell(LAST_CELL + 1, LAST_CELL + 1, 16'sd1);
        write_cell(LAST_CELL + 1, LAST_CELL, 16'sh8000);
        query_cell(LAST_CELL, LAST_CELL, 255, 254);
        query_cell(LAST_CELL, LAST_CELL, 0, 128);
    endtask

    task automatic test_out_of_range();
        send_query(16'hFFFF, 16'h0000);     // negative x
        send_query(16'h0000, 16'h8000);     // negative z
        send_query(16'h3F00, 16'h0000);     // x cell one past the last
        send_query(16'h0000, 16'h3FFF);     // z cell one past the last
        send_query(16'h7FFF, 16'h7FFF);
    endtask

    task automatic test_random_traffic(int n);
        int stop_at;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(19))
                0, 1, 2:    write_cell($urandom_range(GRID_N - 1), $urandom_range(GRID_N - 1),
                                       random_height());
                3, 4, 5, 6: random_noise_query();
                default:    random_query_in_grid();
            endcase
        end
    endtask

    // Receiver holds off while queries keep coming, so the block backs up.
    task automatic test_result_holdoff();
        tx_idle_pct = 0;
        holdoff_left = 300;
        repeat (40)
            random_query_in_grid();
        tx_idle_pct = 29;
    endtask

    task automatic test_drain_pause();
        test_random_traffic(30);
        drain_results();
        test_random_traffic(30);
    endtask

    always @(posedge clk)
    begin
        if (holdoff_left > 0)
        begin
            res_stall    <= 1'b1;
            holdoff_left <= holdoff_left - 1;
        end
        else
            res_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic note_mismatch(string what, res_item_t w, res_item_t g);
        if (mismatch_count < 10)
            $display({"%0t: %s: expected height_out=%0d in_range=%0b,",
                      " got height_out=%0d in_range=%0b"},
                     $realtime, what, w.height_out, w.in_range, g.height_out, g.in_range);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_samples.size() == 0)
                note_mismatch("result with none pending", '0, res);
            else
            begin
                want = expected_samples.pop_front();
                if (res.height_out !== want.height_out)
                    note_mismatch("height_out", want, res);
                if (res.in_range !== want.in_range)
                    note_mismatch("in_range", want, res);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles + 1 >= STUCK_LIMIT)
        begin
            $display("height_grid_triangle_sample regression: fail");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_extremes();
        test_edge_cells();
        test_out_of_range();
        test_random_traffic(600);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(300);
        test_result_holdoff();
        tx_idle_pct = 29;
        rx_idle_pct = 29;
        test_drain_pause();
        test_random_traffic(260);
        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("height_grid_triangle_sample regression: pass");
        else
            $display("height_grid_triangle_sample regression: fail");
        $finish;
    end

endmodule
